FILE: rtl/pcbp_pkg.sv
// Shared types and constants for the prefix code bit packer.
package pcbp_pkg;

  localparam int MaxCodeLen = 32;   // default code length limit
  localparam int SymW       = 8;    // symbol width
  localparam int CodeBitsW  = 32;   // code value field width
  localparam int LenW       = 6;    // code length field width
  localparam int ByteW      = 8;    // output byte width
  localparam int PendW      = 7;    // at most seven bits wait for a byte
  localparam int PendCntW   = 3;
  localparam int TableDepth = 256;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

  // Item held in the lookup stage, offered to the byte emitter.
  typedef struct packed {
    logic            vld;
    logic [1:0]      act;
    logic [LenW-1:0] len;
  } item_t;

endpackage

FILE: rtl/prefix_code_bit_packer.sv
// Item path: lookup stage register, then the accumulator, then the byte output register.
// Throughput: one item per cycle while each item gives at most one byte and out_ready_i is
//   high; an encode that gives more than one byte holds the byte emitter until its last byte
//   is sent, since the single output register sends one byte per beat.
// Reset: asynchronous, active low; clears handshake state, pending bits and the length table's
//   valid bits at once (no clearing pass). The code value table is not reset.
module prefix_code_bit_packer #(
  parameter int MAX_CODE_LEN = pcbp_pkg::MaxCodeLen
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [pcbp_pkg::SymW-1:0]      symbol_i,
  input  logic [pcbp_pkg::CodeBitsW-1:0] code_bits_i,
  input  logic [pcbp_pkg::LenW-1:0]      code_length_i,
  // output beats
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pcbp_pkg::ByteW-1:0]     packed_byte_o,
  output logic                           last_of_run_o
);
  import pcbp_pkg::*;

  // codes longer than the field cannot be stored
  localparam int CodeW = (MAX_CODE_LEN < CodeBitsW) ? MAX_CODE_LEN : CodeBitsW;

  item_t            item;
  logic [CodeW-1:0] code;
  logic             take;

  // Stage 1: loads write the tables; every beat reads its symbol's entry.
  // A load followed at once by an encode of the same symbol sees the new
  // entry, since the write lands on the load's own accept edge.
  pcbp_lookup #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .take_i        (take),
    .item_o        (item),
    .code_o        (code)
  );

  // Stage 2: accumulator plus output register. A new item joins only when
  // fewer than eight bits remain after this cycle's byte, so every byte
  // belongs to exactly one item and the last one is flagged.
  pcbp_byte_emitter #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .code_i        (code),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: rtl/pcbp_lookup.sv
// Input stage: code tables, table loads and registered code lookup.
module pcbp_lookup #(
  parameter int MAX_CODE_LEN = pcbp_pkg::MaxCodeLen,
  localparam int CodeW = (MAX_CODE_LEN < pcbp_pkg::CodeBitsW) ?
                         MAX_CODE_LEN : pcbp_pkg::CodeBitsW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [pcbp_pkg::SymW-1:0]     symbol_i,
  input  logic [pcbp_pkg::CodeBitsW-1:0] code_bits_i,
  input  logic [pcbp_pkg::LenW-1:0]     code_length_i,
  input  logic                          take_i,
  output pcbp_pkg::item_t               item_o,
  output logic [CodeW-1:0]              code_o
);
  import pcbp_pkg::*;

  logic [CodeW-1:0] val_mem [TableDepth];
  logic [LenW-1:0]  len_mem [TableDepth];
  logic [TableDepth-1:0] len_vld_q;

  logic             accept;
  logic             wr_en;
  logic [LenW-1:0]  len_sat;
  logic [CodeW-1:0] code_mask;
  logic [CodeW-1:0] code_rd_q;
  logic [LenW-1:0]  len_rd_q;
  logic             len_vld_rd_q;
  logic             s1_vld_q, s1_vld_d;
  logic [1:0]       s1_act_q;

  assign in_ready_o = !s1_vld_q || take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && (action_i == ACT_LOAD);

  // saturate overlong lengths, keep only the low code bits
  always_comb begin
    len_sat = code_length_i;
    if (code_length_i > LenW'(CodeW)) begin
      len_sat = LenW'(CodeW);
    end
    for (int i = 0; i < CodeW; i++) begin
      code_mask[i] = LenW'(i) < len_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_mem[symbol_i] <= code_bits_i[CodeW-1:0] & code_mask;
      len_mem[symbol_i] <= len_sat;
    end
    if (accept) begin
      code_rd_q <= val_mem[symbol_i];
      len_rd_q  <= len_mem[symbol_i];
      s1_act_q  <= action_i;
    end
  end

  // length table reads zero until an entry is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q    <= '0;
      len_vld_rd_q <= 1'b0;
    end else begin
      if (wr_en) begin
        len_vld_q[symbol_i] <= 1'b1;
      end
      if (accept) begin
        len_vld_rd_q <= len_vld_q[symbol_i];
      end
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (take_i) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  assign item_o.vld = s1_vld_q;
  assign item_o.act = s1_act_q;
  assign item_o.len = len_vld_rd_q ? len_rd_q : '0;
  assign code_o     = code_rd_q;

  // a held item keeps its action and length until the emitter takes it
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_o.vld && !take_i) |=> (item_o.vld && $stable(item_o.act) && $stable(item_o.len)))
    else $error("lookup item changed while stalled");

endmodule

FILE: rtl/pcbp_byte_emitter.sv
// Bit accumulator: merges codes after pending bits and sends out one byte per beat.
module pcbp_byte_emitter #(
  parameter int MAX_CODE_LEN = pcbp_pkg::MaxCodeLen,
  localparam int CodeW = (MAX_CODE_LEN < pcbp_pkg::CodeBitsW) ?
                         MAX_CODE_LEN : pcbp_pkg::CodeBitsW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pcbp_pkg::item_t            item_i,
  input  logic [CodeW-1:0]           code_i,
  output logic                       take_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pcbp_pkg::ByteW-1:0] packed_byte_o,
  output logic                       last_of_run_o
);
  import pcbp_pkg::*;

  localparam int AccW = CodeW + PendW;
  localparam int CntW = $clog2(AccW + 1);

  logic [AccW-1:0]     acc_q, acc_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy;
  logic                slot_free;
  logic                emit;
  logic [CntW-1:0]     cnt_left;
  logic [CntW-1:0]     cnt_after;
  logic [PendCntW-1:0] pend_cnt;
  logic [PendW-1:0]    pend_mask;
  logic [PendW-1:0]    pend;
  logic [ByteW-1:0]    next_byte;
  logic                out_vld_q, out_vld_d;
  logic [ByteW-1:0]    byte_q;
  logic                last_q;

  assign busy      = cnt_q >= CntW'(ByteW);
  assign slot_free = !out_vld_q || out_ready_i;
  assign emit      = busy && slot_free;
  assign cnt_left  = cnt_q - CntW'(ByteW);
  assign cnt_after = emit ? cnt_left : cnt_q;
  assign take_o    = item_i.vld && (cnt_after < CntW'(ByteW));
  assign pend_cnt  = cnt_after[PendCntW-1:0];
  assign next_byte = ByteW'(acc_q >> cnt_left);

  always_comb begin
    for (int i = 0; i < PendW; i++) begin
      pend_mask[i] = PendCntW'(i) < pend_cnt;
    end
    pend = acc_q[PendW-1:0] & pend_mask;
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_after;
    if (take_o) begin
      case (item_i.act)
        ACT_ENCODE: begin
          // symbol without a code: pending bits stay as they are
          if (item_i.len != '0) begin
            acc_d = (AccW'(pend) << item_i.len) | AccW'(code_i);
            cnt_d = CntW'(pend_cnt) + CntW'(item_i.len);
          end
        end
        ACT_FLUSH: begin
          // partial byte goes out left-aligned, zero padded
          if (pend_cnt != '0) begin
            acc_d = AccW'({pend, 1'b0}) << (PendCntW'(PendW) - pend_cnt);
            cnt_d = CntW'(ByteW);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= next_byte;
      last_q <= cnt_left < CntW'(ByteW);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign packed_byte_o = byte_q;
  assign last_of_run_o = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(AccW))
    else $error("bit count beyond accumulator");

  a_flush_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && item_i.act == ACT_FLUSH) |=> (cnt_q == '0 || cnt_q == CntW'(ByteW)))
    else $error("flush left a partial count");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cnt_left >= CntW'(ByteW)) |=> busy)
    else $error("run ended before its last byte");

endmodule
